// ===== rtl/ftcp_pkg.sv =====
// Shared types and constants for the frequency threshold cache policy.
package ftcp_pkg;
  localparam int unsigned ENTRIES_DEFAULT = 256;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [0:0] REG_CACHE_BUDGET = 1'b0;
  localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b1;
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;   // zero one entry of the post-reset clearing pass
    logic load;        // capture item, issue count read
    logic clr_start;   // start clearing sweep; never driven, the sweep runs on clr_step
    logic clr_step;    // clear one entry
    logic rank_start;  // capture count and mark, start a ranking pass
    logic rank_step;   // read one count for the current bit
    logic rank_bit;    // resolve the current threshold bit
    logic thr_update;  // write threshold from rank result
    logic commit;      // update entry and present result
  } ftcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic need_rank;   // count equals threshold
    logic fits;        // budget covers all ranked entries
    logic sweep_last;  // sweep pointer on its last entry
    logic rank_last;   // ranking pointer on its last entry
    logic bit_last;    // ranking on the lowest threshold bit
  } ftcp_stat_t;
endpackage

// ===== rtl/ftcp_datapath.sv =====
// Datapath: count memory, resident marks, threshold and rank search.
module ftcp_datapath import ftcp_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_val,
  input  logic             cfg_sel,
  input  logic             action,
  input  logic [7:0]       entry_index,
  input  ftcp_cmd_t        cmd,
  output ftcp_stat_t       stat,
  output logic             was_resident,
  output logic             resident_after,
  output logic [CNT_W-1:0] access_count,
  output logic [CNT_W-1:0] threshold_now
);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned NW = IW + 1;

  logic [CFG_W-1:0] cache_budget;
  logic [CFG_W-1:0] entries_in_use;
  logic [CNT_W-1:0] mem [ENTRIES];
  logic             mark_mem [ENTRIES];
  logic [CNT_W-1:0] freq_threshold;
  logic             act;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_in;
  logic [IW-1:0]    ptr;
  logic [IW-1:0]    rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic             mark_rd;
  logic             rd_live;
  logic [CNT_W-1:0] cur_cnt;
  logic             cur_mark;
  logic [CNT_W-1:0] new_cnt;
  logic             keep;
  logic             fits;
  logic [NW-1:0]    n_eff;
  logic [CNT_W-1:0] prefix;
  logic [CNT_W-1:0] bit_sel;
  logic [CNT_W-1:0] hi_mask;
  logic [NW-1:0]    k_rem;
  logic [NW-1:0]    hits;
  logic [NW-1:0]    hits_total;
  logic             hit;

  // Reduce an index modulo ENTRIES by compare and subtract; an index below
  // ENTRIES passes through unchanged.
  function automatic logic [IW-1:0] wrap_index(input logic [7:0] v);
    logic [20:0] r;
    r = {13'd0, v};
    for (int k = 8; k >= 0; k--) begin
      if (r >= (21'(ENTRIES) << k)) r = r - (21'(ENTRIES) << k);
    end
    return IW'(r);
  endfunction

  // Ranked entry count, limited to the stored entries.
  always_comb begin
    if (32'(entries_in_use) > 32'(ENTRIES)) n_eff = NW'(ENTRIES);
    else n_eff = NW'(entries_in_use);
  end

  assign idx_in = wrap_index(entry_index);
  assign rd_addr = cmd.load ? idx_in : ptr;
  assign new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
  assign keep = !(new_cnt < freq_threshold);
  assign fits = (32'(cache_budget) >= 32'(n_eff));

  // A count takes part in the current bit when it matches the bits already
  // resolved and has the current bit set.
  assign hit = rd_live && (((rd_data ^ prefix) & hi_mask) == '0) &&
               ((rd_data & bit_sel) != '0);
  assign hits_total = hits + NW'(hit);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_budget <= CFG_W'(256);
      entries_in_use <= CFG_W'(256);
    end else if (cfg_we) begin
      if (cfg_sel == REG_CACHE_BUDGET) cache_budget <= cfg_val;
      else entries_in_use <= cfg_val;
    end
  end

  // Count and mark memories with registered read; sweeps zero counts, the init sweep marks too.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    mark_rd <= mark_mem[rd_addr];
    if (cmd.init_step || cmd.clr_step) mem[ptr] <= '0;
    else if (cmd.commit && !act) mem[idx] <= new_cnt;
    if (cmd.init_step) mark_mem[ptr] <= 1'b0;
    else if (cmd.commit && !act) mark_mem[idx] <= keep;
  end

  // Threshold, sweep pointer and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_threshold <= '0;
      ptr <= '0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.rank_step;
      if (cmd.thr_update) freq_threshold <= fits ? '0 : prefix;
      if (cmd.load || cmd.rank_start || cmd.rank_bit) begin
        ptr <= '0;
      end else if (cmd.init_step || cmd.clr_step || cmd.rank_step) begin
        ptr <= ptr + IW'(1);
      end
    end
  end

  // Item capture, bitwise rank selection from the top bit down, and the
  // result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      idx <= idx_in;
    end
    if (cmd.rank_start) begin
      cur_cnt <= rd_data;
      cur_mark <= mark_rd;
      prefix <= '0;
      bit_sel <= {1'b1, {(CNT_W-1){1'b0}}};
      hi_mask <= '0;
      k_rem <= NW'(cache_budget);
      hits <= '0;
    end else if (cmd.rank_bit) begin
      if (hits_total > k_rem) prefix <= prefix | bit_sel;
      else k_rem <= k_rem - hits_total;
      bit_sel <= bit_sel >> 1;
      hi_mask <= hi_mask | bit_sel;
      hits <= '0;
    end else if (hit) begin
      hits <= hits + NW'(1);
    end
    if (cmd.commit) begin
      was_resident <= act ? 1'b0 : cur_mark;
      resident_after <= act ? 1'b0 : keep;
      access_count <= act ? '0 : new_cnt;
      threshold_now <= freq_threshold;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.is_clear = act;
    stat.need_rank = (cur_cnt == freq_threshold);
    stat.fits = fits;
    stat.sweep_last = (ptr == IW'(ENTRIES - 1));
    stat.rank_last = (NW'(ptr) == n_eff - NW'(1));
    stat.bit_last = bit_sel[0];
  end
endmodule

// ===== rtl/ftcp_ctrl.sv =====
// Controller state machine sequencing access, clear and ranking.
module ftcp_ctrl import ftcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ftcp_stat_t stat,
  output ftcp_cmd_t  cmd,
  output logic       busy,
  output logic       done
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_RANK = 4'd4;
  localparam logic [3:0] S_THR = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_BIT = 4'd7;
  localparam logic [3:0] S_INIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && !busy) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.is_clear) state_next = S_CLEAR;
        else begin
          cmd.rank_start = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.need_rank) state_next = S_COMMIT;
        else if (stat.fits) state_next = S_THR;
        else state_next = S_RANK;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) state_next = S_COMMIT;
      end
      S_RANK: begin
        cmd.rank_step = 1'b1;
        if (stat.rank_last) state_next = S_BIT;
      end
      S_BIT: begin
        cmd.rank_bit = 1'b1;
        if (stat.bit_last) state_next = S_THR;
        else state_next = S_RANK;
      end
      S_THR: begin
        cmd.thr_update = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.commit;
    end
  end

  assign busy = (state != S_IDLE) || done;

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit) else $error("double commit");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.commit)) else $error("done without commit");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE && !done) else $error("load while busy");
endmodule

// ===== rtl/frequency_threshold_cache_policy.sv =====
// Top level of the frequency threshold cache policy.
//
// Usage: raise start with action and entry_index while busy is low; the
// item transfers at that edge. One result follows, marked by done high for
// exactly one cycle, with was_resident, resident_after, access_count
// and threshold_now. The receiver cannot stall; results must be taken.
// Configuration: cfg_we with cfg_index (0 cache_budget, 1 entries_in_use)
// and cfg_data, written while the block is idle.
// An access that keeps the threshold steps through READ, CHECK and COMMIT;
// one that recomputes it while everything fits also passes THR. A clear
// zeroes one count per cycle. A ranked recompute resolves the threshold one
// bit per pass over N = min(entries_in_use, ENTRIES) counts, in 32 passes.
// Busy covers the done cycle, so the next start transfers in the cycle
// after done at the earliest.
// Reset sets both registers to 256 and the threshold to zero; a clearing
// pass then zeroes counts and marks while busy is high.
module frequency_threshold_cache_policy import ftcp_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  input  logic             action,
  input  logic [7:0]       entry_index,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             was_resident,
  output logic             resident_after,
  output logic [CNT_W-1:0] access_count,
  output logic [CNT_W-1:0] threshold_now
);
  ftcp_cmd_t  cmd;
  ftcp_stat_t stat;

  ftcp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(done)
  );

  ftcp_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_val(cfg_data),
    .cfg_sel(cfg_index), .action(action), .entry_index(entry_index),
    .cmd(cmd), .stat(stat), .was_resident(was_resident),
    .resident_after(resident_after), .access_count(access_count),
    .threshold_now(threshold_now)
  );
endmodule

// ===== tb/sv/frequency_threshold_cache_policy_checker.sv =====
// Checker that predicts and compares every result of the frequency threshold cache policy.
module frequency_threshold_cache_policy_checker import ftcp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             done,
  input  logic             action,
  input  logic [7:0]       entry_index,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             was_resident,
  input  logic             resident_after,
  input  logic [CNT_W-1:0] access_count,
  input  logic [CNT_W-1:0] threshold_now,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  typedef struct {
    logic             was_res;
    logic             res_after;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] thresh;
  } residency_t;

  // Shadow state of the policy.
  logic [CNT_W-1:0] hit_counts [256];
  logic             resident [256];
  logic [CNT_W-1:0] threshold;
  logic [CFG_W-1:0] budget;
  logic [CFG_W-1:0] in_use;
  residency_t       awaited [$];

  // Threshold is the count at rank budget among the tracked entries, largest first.
  function automatic void rank_threshold();
    logic [CNT_W-1:0] ranked [$];
    int n;
    n = (in_use > 256) ? 256 : int'(in_use);
    if (budget >= n) begin
      threshold = '0;
    end else begin
      for (int i = 0; i < n; i++) ranked.insert(ranked.size(), hit_counts[i]);
      ranked.rsort();
      threshold = ranked[budget];
    end
  endfunction

  function automatic residency_t predict_access(logic act, logic [7:0] idx);
    residency_t r;
    if (act == ACT_CLEAR) begin
      foreach (hit_counts[i]) hit_counts[i] = '0;
      r.was_res = 1'b0;
      r.res_after = 1'b0;
      r.count = '0;
      r.thresh = threshold;
      return r;
    end
    r.was_res = resident[idx];
    if (hit_counts[idx] == threshold) rank_threshold();
    if (hit_counts[idx] != CNT_MAX) hit_counts[idx] = hit_counts[idx] + 1;
    resident[idx] = !(hit_counts[idx] < threshold);
    r.res_after = resident[idx];
    r.count = hit_counts[idx];
    r.thresh = threshold;
    return r;
  endfunction

  always @(posedge clk) begin
    residency_t e;
    if (rst) begin
      foreach (hit_counts[i]) begin
        hit_counts[i] = '0;
        resident[i] = 1'b0;
      end
      threshold = '0;
      budget = 9'd256;
      in_use = 9'd256;
      awaited.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // Compare a finished result with the oldest prediction.
      if (done) begin
        checked++;
        if (awaited.size() == 0) begin
          $error("result with no transfer outstanding");
          fail_count++;
        end else begin
          e = awaited.pop_front();
          if (was_resident !== e.was_res) begin
            $error("was_resident: expected %0d actual %0d", e.was_res, was_resident);
            fail_count++;
          end
          if (resident_after !== e.res_after) begin
            $error("resident_after: expected %0d actual %0d", e.res_after, resident_after);
            fail_count++;
          end
          if (access_count !== e.count) begin
            $error("access_count: expected %0d actual %0d", e.count, access_count);
            fail_count++;
          end
          if (threshold_now !== e.thresh) begin
            $error("threshold_now: expected %0d actual %0d", e.thresh, threshold_now);
            fail_count++;
          end
        end
      end
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == REG_CACHE_BUDGET) budget = cfg_data;
        else in_use = cfg_data;
      end
      // Accepted transfer.
      if (start && !busy) awaited.insert(awaited.size(), predict_access(action, entry_index));
    end
    pending = awaited.size();
  end

endmodule

// ===== tb/sv/frequency_threshold_cache_policy_test.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the cache policy.
module frequency_threshold_cache_policy_test import ftcp_pkg::*;;

  localparam int LIMIT_CYCLES = 40_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             action = ACT_ACCESS;
  logic [7:0]       entry_index = '0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_CACHE_BUDGET;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             busy, done, was_resident, resident_after;
  logic [CNT_W-1:0] access_count, threshold_now;
  int               fail_count, pending, checked;
  int               idle_pct = 0;
  int               sent = 0;
  int               clears = 0;
  int               cycles = 0;
  int               settings = 0;

  always #4 clk = ~clk;

  frequency_threshold_cache_policy i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .action(action), .entry_index(entry_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .was_resident(was_resident), .resident_after(resident_after),
    .access_count(access_count), .threshold_now(threshold_now)
  );

  frequency_threshold_cache_policy_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .action(action), .entry_index(entry_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .was_resident(was_resident), .resident_after(resident_after),
    .access_count(access_count), .threshold_now(threshold_now),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One transfer, with random idle cycles in front of it.
  task automatic issue(logic act, logic [7:0] idx);
    @(negedge clk);
    while ($urandom_range(99, 0) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    action = act;
    entry_index = idx;
    do @(posedge clk); while (busy);
    sent++;
    if (act == ACT_CLEAR) clears++;
  endtask

  // Register write, only once the block has drained.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_policy(int budget, int in_use);
    write_reg(REG_CACHE_BUDGET, CFG_W'(budget));
    write_reg(REG_ENTRIES_IN_USE, CFG_W'(in_use));
    settings++;
  endtask

  // Mostly tracked entries, some beyond the ranked range, a few clears.
  task automatic random_burst(int n, int in_use);
    int hi;
    hi = (in_use < 1) ? 0 : ((in_use > 256) ? 255 : in_use - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 4) issue(ACT_CLEAR, 8'($urandom));
      else if ($urandom_range(99, 0) < 80) issue(ACT_ACCESS, 8'($urandom_range(hi, 0)));
      else issue(ACT_ACCESS, 8'($urandom));
    end
  endtask

  initial begin
    int budgets [10] = '{0, 2, 5, 3, 16, 7, 0, 300, 255, 1};
    int in_uses [10] = '{1, 8, 16, 4, 16, 12, 0, 511, 255, 2};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: everything fits at reset, field extremes and a clear.
    issue(ACT_ACCESS, 8'd0);
    issue(ACT_ACCESS, 8'd255);
    issue(ACT_ACCESS, 8'd255);
    issue(ACT_ACCESS, 8'd170);
    issue(ACT_CLEAR, 8'd85);
    issue(ACT_ACCESS, 8'd0);

    // Directed: small tracked set, so ranking and unloading happen.
    set_policy(1, 4);
    for (int i = 0; i < 4; i++) issue(ACT_ACCESS, 8'(i));
    issue(ACT_ACCESS, 8'd2);
    issue(ACT_ACCESS, 8'd2);
    issue(ACT_ACCESS, 8'd3);
    issue(ACT_ACCESS, 8'd200);
    issue(ACT_ACCESS, 8'd1);
    issue(ACT_CLEAR, 8'd0);
    issue(ACT_ACCESS, 8'd0);
    issue(ACT_ACCESS, 8'd1);

    // Random phases across settings and idle patterns.
    for (int p = 0; p < 10; p++) begin
      set_policy(budgets[p], in_uses[p]);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 60 : 15);
      random_burst(95, in_uses[p]);
    end

    // A few items with the full ranked range, where ranking is slow.
    set_policy(100, 256);
    idle_pct = 0;
    random_burst(6, 256);
    set_policy(256, 256);
    random_burst(10, 256);

    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);

    $display("Sent %0d transfers (%0d clears) over %0d policy settings.",
             sent, clears, settings);
    $display("Checked %0d results with %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
